// File: sv/dtt_pkg.sv
`default_nettype none
package dtt_pkg;

    // request codes (carried in s_tuser)
    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_CANCEL  = 3'd1;
    localparam logic [2:0] REQ_RESET   = 3'd2;
    localparam logic [2:0] REQ_REFRESH = 3'd3;
    localparam logic [2:0] REQ_EXPIRE  = 3'd4;
    localparam logic [2:0] REQ_QUERY   = 3'd5;

    // result status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FAIL = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    localparam logic [63:0] HOUR_MS  = 64'd3600000;
    localparam logic [63:0] ALL_ONES = '1;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_CALC, ST_APPLY, ST_ESCAN, ST_EOUT
    } state_t;

    typedef struct packed {
        logic load;        // capture request, clear first-pass accumulators
        logic scan_start;  // restart table sweep
        logic emit_pass;   // sweep selects among due timers
        logic calc;        // form new deadline
        logic apply;       // update table and result for the request
        logic emit;        // send one expired timer
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic is_exp;
        logic due_any;
        logic more;
    } stat_t;

endpackage
`default_nettype wire

// File: sv/dtt_ctrl.sv
`default_nettype none
module dtt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire dtt_pkg::stat_t stat,
    output dtt_pkg::cmd_t      cmd
);

    dtt_pkg::state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dtt_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = dtt_pkg::ST_SCAN;
            end
            dtt_pkg::ST_SCAN: begin
                if (stat.scan_done) state_next = dtt_pkg::ST_CALC;
            end
            dtt_pkg::ST_CALC: state_next = dtt_pkg::ST_APPLY;
            dtt_pkg::ST_APPLY: begin
                if (stat.is_exp) begin
                    state_next = stat.due_any ? dtt_pkg::ST_ESCAN : dtt_pkg::ST_IDLE;
                end else if (stat.out_free) begin
                    state_next = dtt_pkg::ST_IDLE;
                end
            end
            dtt_pkg::ST_ESCAN: begin
                if (stat.scan_done) state_next = dtt_pkg::ST_EOUT;
            end
            dtt_pkg::ST_EOUT: begin
                if (stat.out_free) begin
                    state_next = stat.more ? dtt_pkg::ST_ESCAN : dtt_pkg::ST_IDLE;
                end
            end
            default: state_next = dtt_pkg::ST_IDLE;
        endcase
    end

    // drive commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            dtt_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.load       = s_tvalid;
                cmd.scan_start = s_tvalid;
            end
            dtt_pkg::ST_SCAN: ;
            dtt_pkg::ST_CALC: cmd.calc = 1'b1;
            dtt_pkg::ST_APPLY: begin
                cmd.apply      = stat.is_exp || stat.out_free;
                cmd.scan_start = stat.is_exp && stat.due_any;
            end
            dtt_pkg::ST_ESCAN: cmd.emit_pass = 1'b1;
            dtt_pkg::ST_EOUT: begin
                cmd.emit_pass  = 1'b1;
                cmd.emit       = stat.out_free;
                cmd.scan_start = stat.out_free && stat.more;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/dtt_datapath.sv
`default_nettype none
module dtt_datapath #(
    parameter int SLOTS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dtt_pkg::cmd_t                  cmd,
    output dtt_pkg::stat_t                      stat,
    input  wire logic [dtt_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [2:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [dtt_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // captured request
    logic [2:0]  req_type_reg;
    logic [3:0]  req_slot_reg;
    logic [63:0] req_per_reg;
    logic        req_rep_reg;
    logic        req_fnow_reg;
    logic [63:0] req_now_reg;
    logic        roll_reg;
    logic [63:0] last_time_reg;

    // timer table
    logic [63:0] mem_p [SLOTS];
    logic [63:0] mem_d [SLOTS];
    logic [SLOTS-1:0] active_reg, rep_reg, due_reg;

    // sweep
    logic [IW:0]   cnt_reg;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [63:0]   rd_p_reg, rd_d_reg;

    // sweep accumulators
    logic          any_all_reg, any_oth_reg, any_after_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic          min_found_reg;
    logic [63:0]   min_d_reg;
    logic [IW-1:0] min_i_reg;
    logic [63:0]   best_p_reg;
    logic          more_reg, due_any_reg;
    logic [63:0]   tgt_p_reg, start_reg;
    logic          tgt_act_reg;
    logic [63:0]   newd_reg;

    // result register
    logic        m_valid_reg;
    logic [3:0]  out_slot_reg;
    logic [1:0]  out_status_reg;
    logic [63:0] out_wait_reg;
    logic        out_front_reg, out_any_reg, out_last_reg;

    logic          issue, in_range, rd_act, rd_tgt, due_k, cand, better, out_free;
    logic [IW-1:0] s_idx;

    assign issue    = cnt_reg < (IW+1)'(SLOTS);
    assign in_range = 32'(req_slot_reg) < SLOTS;
    assign s_idx    = IW'(req_slot_reg);
    assign rd_act   = active_reg[rd_idx_reg];
    assign rd_tgt   = in_range && (rd_idx_reg == s_idx);
    assign due_k    = rd_act && (roll_reg || (rd_d_reg <= req_now_reg));
    assign cand     = cmd.emit_pass ? due_reg[rd_idx_reg]
                    : (rd_act && !((req_type_reg == dtt_pkg::REQ_RESET) && rd_tgt));
    assign better   = rd_vld_reg && cand && (!min_found_reg || (rd_d_reg < min_d_reg));
    assign out_free = !m_valid_reg || m_tready;

    assign stat.scan_done = rd_vld_reg && (rd_idx_reg == IW'(SLOTS-1));
    assign stat.out_free  = out_free;
    assign stat.is_exp    = req_type_reg == dtt_pkg::REQ_EXPIRE;
    assign stat.due_any   = due_any_reg;
    assign stat.more      = more_reg;

    // result and table update for the current request
    logic          wr_en, set_act, clr_act, front_ok;
    logic [IW-1:0] wr_idx;
    logic [63:0]   wr_p, wr_d;
    logic [3:0]    o_slot;
    logic [1:0]    o_status;
    logic [63:0]   o_wait;
    logic          o_front, o_any;
    logic [IW-1:0] front_idx;

    assign front_idx = (req_type_reg == dtt_pkg::REQ_ADD) ? free_idx_reg : s_idx;
    assign front_ok  = !min_found_reg || (newd_reg < min_d_reg)
                     || ((newd_reg == min_d_reg) && (front_idx < min_i_reg));

    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = s_idx;
        wr_p     = req_per_reg;
        wr_d     = newd_reg;
        set_act  = 1'b0;
        clr_act  = 1'b0;
        o_slot   = 4'd0;
        o_status = dtt_pkg::STS_FAIL;
        o_wait   = 64'd0;
        o_front  = 1'b0;
        o_any    = any_all_reg;
        if (cmd.emit) begin
            wr_idx   = min_i_reg;
            wr_p     = best_p_reg;
            wr_d     = req_now_reg + best_p_reg;
            wr_en    = rep_reg[min_i_reg];
            clr_act  = !rep_reg[min_i_reg];
            o_slot   = 4'(min_i_reg);
            o_status = dtt_pkg::STS_OK;
            o_any    = any_after_reg;
        end else begin
            case (req_type_reg)
                dtt_pkg::REQ_ADD: begin
                    if (free_found_reg) begin
                        wr_en    = 1'b1;
                        wr_idx   = free_idx_reg;
                        set_act  = 1'b1;
                        o_slot   = 4'(free_idx_reg);
                        o_status = dtt_pkg::STS_OK;
                        o_front  = front_ok;
                        o_any    = 1'b1;
                    end else begin
                        o_status = dtt_pkg::STS_FULL;
                    end
                end
                dtt_pkg::REQ_CANCEL: begin
                    if (in_range && tgt_act_reg) begin
                        clr_act  = 1'b1;
                        o_status = dtt_pkg::STS_OK;
                        o_any    = any_oth_reg;
                    end
                end
                dtt_pkg::REQ_RESET: begin
                    if (in_range) begin
                        if ((req_per_reg == tgt_p_reg) && !req_fnow_reg) begin
                            o_status = dtt_pkg::STS_OK;
                        end else if (tgt_act_reg) begin
                            wr_en    = 1'b1;
                            o_status = dtt_pkg::STS_OK;
                            o_front  = front_ok;
                        end
                    end
                end
                dtt_pkg::REQ_REFRESH: begin
                    if (in_range && tgt_act_reg) begin
                        wr_en    = 1'b1;
                        wr_p     = tgt_p_reg;
                        o_status = dtt_pkg::STS_OK;
                    end
                end
                dtt_pkg::REQ_QUERY: begin
                    o_status = dtt_pkg::STS_OK;
                    if (!min_found_reg) o_wait = dtt_pkg::ALL_ONES;
                    else if (req_now_reg >= min_d_reg) o_wait = 64'd0;
                    else o_wait = min_d_reg - req_now_reg;
                end
                default: ;
            endcase
            if (!cmd.apply || (req_type_reg == dtt_pkg::REQ_EXPIRE)) begin
                wr_en   = 1'b0;
                set_act = 1'b0;
                clr_act = 1'b0;
            end
        end
    end

    // table memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_p[wr_idx] <= wr_p;
            mem_d[wr_idx] <= wr_d;
        end
        rd_p_reg <= mem_p[cnt_reg[IW-1:0]];
        rd_d_reg <= mem_d[cnt_reg[IW-1:0]];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= '0;
            rep_reg       <= '0;
            due_reg       <= '0;
            cnt_reg       <= (IW+1)'(SLOTS);
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_time_reg <= 64'd0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.scan_start) cnt_reg <= '0;
            else if (issue) cnt_reg <= cnt_reg + 1'b1;
            if (rd_vld_reg && !cmd.emit_pass) due_reg[rd_idx_reg] <= due_k;
            if (cmd.emit) due_reg[min_i_reg] <= 1'b0;
            if (set_act) begin
                active_reg[wr_idx] <= 1'b1;
                rep_reg[wr_idx]    <= req_rep_reg;
            end
            if (clr_act) active_reg[wr_idx] <= 1'b0;
            if (cmd.apply && stat.is_exp && any_all_reg) last_time_reg <= req_now_reg;
            if (cmd.emit || (cmd.apply && !stat.is_exp)) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // request, accumulators and result payload
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg[IW-1:0];
        if (cmd.load) begin
            req_type_reg   <= s_tuser;
            req_slot_reg   <= s_tdata[3:0];
            req_per_reg    <= s_tdata[67:4];
            req_rep_reg    <= s_tdata[68];
            req_fnow_reg   <= s_tdata[69];
            req_now_reg    <= s_tdata[133:70];
            roll_reg       <= (s_tdata[133:70] < last_time_reg)
                           && ((last_time_reg - s_tdata[133:70]) > dtt_pkg::HOUR_MS);
            any_all_reg    <= 1'b0;
            any_oth_reg    <= 1'b0;
            any_after_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            due_any_reg    <= 1'b0;
            tgt_act_reg    <= 1'b0;
        end
        if (cmd.scan_start) begin
            min_found_reg <= 1'b0;
            more_reg      <= 1'b0;
        end
        // fold one table entry per cycle
        if (rd_vld_reg) begin
            if (!cmd.emit_pass) begin
                any_all_reg   <= any_all_reg || rd_act;
                any_oth_reg   <= any_oth_reg || (rd_act && !rd_tgt);
                any_after_reg <= any_after_reg || (rd_act && (!due_k || rep_reg[rd_idx_reg]));
                due_any_reg   <= due_any_reg || due_k;
                if (!rd_act && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
                if (rd_tgt) begin
                    tgt_p_reg   <= rd_p_reg;
                    start_reg   <= rd_d_reg - rd_p_reg;
                    tgt_act_reg <= rd_act;
                end
            end else if (cand && min_found_reg) begin
                more_reg <= 1'b1;
            end
            if (better) begin
                min_found_reg <= 1'b1;
                min_d_reg     <= rd_d_reg;
                min_i_reg     <= rd_idx_reg;
                best_p_reg    <= rd_p_reg;
            end
        end
        if (cmd.calc) begin
            newd_reg <= (((req_type_reg == dtt_pkg::REQ_RESET) && !req_fnow_reg)
                         ? start_reg : req_now_reg)
                      + ((req_type_reg == dtt_pkg::REQ_REFRESH) ? tgt_p_reg : req_per_reg);
        end
        if (cmd.emit || (cmd.apply && !stat.is_exp)) begin
            out_slot_reg   <= o_slot;
            out_status_reg <= o_status;
            out_wait_reg   <= o_wait;
            out_front_reg  <= o_front;
            out_any_reg    <= o_any;
            out_last_reg   <= !cmd.emit || !more_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_any_reg, out_front_reg, out_wait_reg, out_status_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// File: sv/deadline_timer_table.sv
// Each request sweeps the slot table through the period/deadline read port, one
// slot a cycle, and a result follows the sweep; the next request is taken only once
// the block is back in idle. Expire gives its first result after a second sweep,
// then one more per further sweep; a stalled result holds the sequence.
// Synchronous active-low reset clears active and repeat flags, last time and the
// result valid flag; period and deadline stay unwritten.
`default_nettype none
module deadline_timer_table #(
    parameter int SLOTS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // timer_slot[3:0] period_ms[67:4] repeat_req[68] restart_now[69] now_ms[133:70]
    input  wire logic [dtt_pkg::IN_DATA_W-1:0] s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // slot_out[3:0] status[5:4] wait_ms[69:6] front_changed[70] any_active[71]
    output logic [dtt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    dtt_pkg::cmd_t  cmd;
    dtt_pkg::stat_t stat;

    // sequence each request
    dtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold the table and form results
    dtt_datapath #(.SLOTS(SLOTS)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: sv/dtt_checker.sv
`default_nettype none
module dtt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast
);

    // status code three is never produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:4] <= dtt_pkg::STS_FULL))
        else $error("undefined status code");

    // only expire gives several results, all successful
    a_multi_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[5:4] == dtt_pkg::STS_OK))
        else $error("non-final result without success");

    // wait time only comes with success
    a_wait_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[69:6] != 64'd0)) |-> (m_tdata[5:4] == dtt_pkg::STS_OK))
        else $error("wait time on failed request");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: verif/deadline_timer_table_test.sv
`timescale 1ns / 100ps
`default_nettype none
module deadline_timer_table_test;

    localparam int NSLOT = 16;
    localparam int LAT = 2 * (NSLOT + 4);
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [63:0] per;
        logic        rep;
        logic        fnow;
        logic [63:0] now;
    } timer_req_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  sts;
        logic [63:0] wait_ms;
        logic        front;
        logic        busy;
        logic        last;
    } timer_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dtt_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dtt_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;

    deadline_timer_table #(.SLOTS(NSLOT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    // shadow timer table
    logic        tb_active [NSLOT];
    logic        tb_repeat [NSLOT];
    logic [63:0] tb_period [NSLOT];
    logic [63:0] tb_deadline [NSLOT];
    logic        tb_written [NSLOT];
    logic [63:0] tb_last_time;

    timer_req_t  pending_reqs[$];
    timer_resp_t expected_resps[$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          stim_done = 1'b0;
    bit          hold_sender = 1'b0;
    bit          long_stall_go = 1'b0;
    bit          rx_hold = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic bit any_timer();
        for (int i = 0; i < NSLOT; i++) if (tb_active[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int earliest_slot();
        int best;
        best = NSLOT;
        for (int i = 0; i < NSLOT; i++) begin
            if (!tb_active[i]) continue;
            if (best == NSLOT || tb_deadline[i] < tb_deadline[best]) best = i;
        end
        return best;
    endfunction

    function automatic timer_resp_t mk(int slot, logic [1:0] sts, logic [63:0] w,
                                       logic front, logic last);
        timer_resp_t r;
        r.slot = slot[3:0]; r.sts = sts; r.wait_ms = w; r.front = front;
        r.busy = any_timer(); r.last = last;
        return r;
    endfunction

    // compute the results of one request and advance the shadow table
    task automatic predict_timer_req(input timer_req_t q);
        int i, e, n;
        int order[$];
        bit picked [NSLOT];
        logic [63:0] start;
        logic roll;
        logic [63:0] w;
        case (q.kind)
            dtt_pkg::REQ_ADD: begin
                for (i = 0; i < NSLOT; i++) if (!tb_active[i]) break;
                if (i == NSLOT) begin
                    expected_resps.push_back(mk(0, dtt_pkg::STS_FULL, 64'd0, 1'b0, 1'b1));
                end else begin
                    tb_active[i] = 1'b1; tb_repeat[i] = q.rep; tb_period[i] = q.per;
                    tb_written[i] = 1'b1; tb_deadline[i] = q.now + q.per;
                    expected_resps.push_back(mk(i, dtt_pkg::STS_OK, 64'd0,
                                                earliest_slot() == i, 1'b1));
                end
            end
            dtt_pkg::REQ_CANCEL: begin
                if (tb_active[q.slot]) begin
                    tb_active[q.slot] = 1'b0;
                    expected_resps.push_back(mk(0, dtt_pkg::STS_OK, 64'd0, 1'b0, 1'b1));
                end else expected_resps.push_back(mk(0, dtt_pkg::STS_FAIL, 64'd0, 1'b0, 1'b1));
            end
            dtt_pkg::REQ_RESET: begin
                if (q.per == tb_period[q.slot] && !q.fnow)
                    expected_resps.push_back(mk(0, dtt_pkg::STS_OK, 64'd0, 1'b0, 1'b1));
                else if (!tb_active[q.slot])
                    expected_resps.push_back(mk(0, dtt_pkg::STS_FAIL, 64'd0, 1'b0, 1'b1));
                else begin
                    start = q.fnow ? q.now : tb_deadline[q.slot] - tb_period[q.slot];
                    tb_period[q.slot] = q.per;
                    tb_deadline[q.slot] = start + q.per;
                    expected_resps.push_back(mk(0, dtt_pkg::STS_OK, 64'd0,
                                                earliest_slot() == q.slot, 1'b1));
                end
            end
            dtt_pkg::REQ_REFRESH: begin
                if (!tb_active[q.slot])
                    expected_resps.push_back(mk(0, dtt_pkg::STS_FAIL, 64'd0, 1'b0, 1'b1));
                else begin
                    tb_deadline[q.slot] = q.now + tb_period[q.slot];
                    expected_resps.push_back(mk(0, dtt_pkg::STS_OK, 64'd0, 1'b0, 1'b1));
                end
            end
            dtt_pkg::REQ_EXPIRE: begin
                e = earliest_slot();
                if (e != NSLOT) begin
                    roll = q.now < tb_last_time && (tb_last_time - q.now) > dtt_pkg::HOUR_MS;
                    tb_last_time = q.now;
                    if (roll || tb_deadline[e] <= q.now) begin
                        for (int k = 0; k < NSLOT; k++) picked[k] = 1'b0;
                        // earliest-first selection, ties to the lower slot
                        for (int k = 0; k < NSLOT; k++) begin
                            int best;
                            best = NSLOT;
                            for (i = 0; i < NSLOT; i++) begin
                                if (!tb_active[i] || !(roll || tb_deadline[i] <= q.now))
                                    continue;
                                if (picked[i]) continue;
                                if (best == NSLOT || tb_deadline[i] < tb_deadline[best])
                                    best = i;
                            end
                            if (best == NSLOT) break;
                            picked[best] = 1'b1;
                            order.push_back(best);
                        end
                        foreach (order[k]) begin
                            if (tb_repeat[order[k]])
                                tb_deadline[order[k]] = q.now + tb_period[order[k]];
                            else tb_active[order[k]] = 1'b0;
                        end
                        n = order.size();
                        foreach (order[k])
                            expected_resps.push_back(mk(order[k], dtt_pkg::STS_OK, 64'd0,
                                                        1'b0, k + 1 == n));
                    end
                end
            end
            dtt_pkg::REQ_QUERY: begin
                e = earliest_slot();
                if (e == NSLOT) w = dtt_pkg::ALL_ONES;
                else if (q.now >= tb_deadline[e]) w = 64'd0;
                else w = tb_deadline[e] - q.now;
                expected_resps.push_back(mk(0, dtt_pkg::STS_OK, w, 1'b0, 1'b1));
            end
            default: expected_resps.push_back(mk(0, dtt_pkg::STS_FAIL, 64'd0, 1'b0, 1'b1));
        endcase
    endtask

    // driver: offer queued requests after a random gap
    int tx_gap = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                s_tvalid <= 1'b0;
                tx_gap = $urandom_range(0, 9);
                if (($urandom & 3) == 0) tx_gap = 0;
            end else if (!s_tvalid && !hold_sender && pending_reqs.size() > 0) begin
                if (tx_gap > 0) tx_gap--;
                else begin
                    timer_req_t q;
                    q = pending_reqs.pop_front();
                    // keep reset away from periods that were never stored
                    if (q.kind == dtt_pkg::REQ_RESET && !tb_written[q.slot]) q.fnow = 1'b1;
                    predict_timer_req(q);
                    s_tuser <= q.kind;
                    s_tdata <= {2'b00, q.now, q.fnow, q.rep, q.per, q.slot};
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // long receiver stall, counted here
    initial begin
        wait (long_stall_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // monitor: check results, stall at random
    int rx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                timer_resp_t got, exp_r;
                got = {m_tdata[3:0], m_tdata[5:4], m_tdata[69:6], m_tdata[70],
                       m_tdata[71], m_tlast};
                if (expected_resps.size() == 0) report_mismatch("unexpected result");
                else begin
                    exp_r = expected_resps.pop_front();
                    if (got.slot != exp_r.slot)
                        report_mismatch($sformatf("slot %0d exp %0d", got.slot, exp_r.slot));
                    if (got.sts != exp_r.sts)
                        report_mismatch($sformatf("status %0d exp %0d", got.sts, exp_r.sts));
                    if (got.wait_ms != exp_r.wait_ms)
                        report_mismatch($sformatf("wait %0h exp %0h", got.wait_ms,
                                                  exp_r.wait_ms));
                    if (got.front != exp_r.front)
                        report_mismatch($sformatf("front %0b exp %0b", got.front, exp_r.front));
                    if (got.busy != exp_r.busy)
                        report_mismatch($sformatf("active %0b exp %0b", got.busy, exp_r.busy));
                    if (got.last != exp_r.last)
                        report_mismatch($sformatf("last %0b exp %0b", got.last, exp_r.last));
                end
                rx_gap = $urandom_range(0, 9);
                if (($urandom & 3) == 0) rx_gap = 0;
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    // random request; small times near a base
    function automatic timer_req_t rand_req(longint base);
        timer_req_t q;
        int r;
        r = $urandom_range(0, 99);
        q.kind = r < 25 ? dtt_pkg::REQ_ADD : r < 35 ? dtt_pkg::REQ_CANCEL :
                 r < 50 ? dtt_pkg::REQ_RESET : r < 60 ? dtt_pkg::REQ_REFRESH :
                 r < 85 ? dtt_pkg::REQ_EXPIRE : r < 97 ? dtt_pkg::REQ_QUERY :
                 3'($urandom_range(6, 7));
        q.slot = 4'($urandom_range(0, NSLOT - 1));
        q.per = ($urandom & 7) == 0 ? {$urandom, $urandom} : 64'($urandom_range(0, 300));
        q.rep = 1'($urandom & 1);
        q.fnow = 1'($urandom & 1);
        q.now = ($urandom & 31) == 0 ? {$urandom, $urandom}
                                     : 64'(base) + 64'($urandom_range(0, 400));
        return q;
    endfunction

    function automatic timer_req_t mkreq(logic [2:0] k, int slot, logic [63:0] per,
                                         logic rep, logic fnow, logic [63:0] now);
        timer_req_t q;
        q.kind = k; q.slot = slot[3:0]; q.per = per; q.rep = rep; q.fnow = fnow; q.now = now;
        return q;
    endfunction

    initial begin
        timer_req_t q;
        longint base;
        int accepted_rand;
        foreach (tb_active[i]) begin
            tb_active[i] = 1'b0; tb_repeat[i] = 1'b0; tb_period[i] = 64'd0;
            tb_deadline[i] = 64'd0; tb_written[i] = 1'b0;
        end
        tb_last_time = 64'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, every request kind, full table
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_QUERY, 0, 64'd0, 1'b0, 1'b0, 64'd0));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_EXPIRE, 0, 64'd0, 1'b0, 1'b0, 64'd5));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_CANCEL, 3, 64'd0, 1'b0, 1'b0, 64'd0));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_REFRESH, 15, 64'd0, 1'b0, 1'b0, 64'd0));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_ADD, 0, dtt_pkg::ALL_ONES, 1'b1, 1'b1,
                                     dtt_pkg::ALL_ONES));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_ADD, 0, 64'd100, 1'b0, 1'b0, 64'd1000));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_RESET, 1, 64'd100, 1'b0, 1'b0, 64'd1000));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_RESET, 1, 64'd50, 1'b0, 1'b0, 64'd1010));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_RESET, 0, 64'd5, 1'b1, 1'b1, 64'd1020));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_QUERY, 0, 64'd0, 1'b0, 1'b0, 64'd1021));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_REFRESH, 1, 64'd0, 1'b0, 1'b0, 64'd1030));
        for (int i = 0; i < 15; i++)
            pending_reqs.push_back(mkreq(dtt_pkg::REQ_ADD, 0, 64'd7, 1'(i & 1), 1'b0,
                                         64'd2000));
        pending_reqs.push_back(mkreq(3'd6, 0, 64'd0, 1'b0, 1'b0, 64'd0));
        pending_reqs.push_back(mkreq(3'd7, 0, 64'd0, 1'b0, 1'b0, 64'd0));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_EXPIRE, 0, 64'd0, 1'b0, 1'b0, 64'd3000));
        pending_reqs.push_back(mkreq(dtt_pkg::REQ_EXPIRE, 0, 64'd0, 1'b0, 1'b0,
                                     64'd3000 - 64'd3600001));
        wait (pending_reqs.size() == 0);
        @(posedge aclk);
        wait (expected_resps.size() == 0 && !s_tvalid);

        // long receiver stall while the sender keeps offering
        long_stall_go = 1'b1;
        base = 10000;
        accepted_rand = 0;
        while (accepted_rand < 150) begin
            q = rand_req(base);
            pending_reqs.push_back(q);
            accepted_rand++;
            if ((accepted_rand % 20) == 0) base += $urandom_range(0, 500);
            if (accepted_rand == 75) begin
                // drain pause
                wait (pending_reqs.size() == 0);
                @(posedge aclk);
                wait (!s_tvalid);
                hold_sender = 1'b1;
                wait (expected_resps.size() == 0);
                repeat (LAT) @(posedge aclk);
                hold_sender = 1'b0;
                pending_reqs.push_back(mkreq(dtt_pkg::REQ_EXPIRE, 0, 64'd0, 1'b0, 1'b0,
                                             64'(base) - 64'd5000000));
            end
        end
        wait (pending_reqs.size() == 0);
        @(posedge aclk);
        wait (!s_tvalid);
        stim_done = 1'b1;
    end

    // end of run and timeout
    initial begin
        wait (stim_done && expected_resps.size() == 0);
        repeat (LAT) @(posedge aclk);
        if (error_count == 0 && expected_resps.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT with %0d results outstanding", expected_resps.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end
endmodule
`default_nettype wire
